// ===== design/pmc_pkg.sv =====
// Shared mode codes, enable masks and request type for the power mode controller.
`timescale 1ns / 1ps
`default_nettype none

package pmc_pkg;

    localparam int ModeW = 4;
    localparam int MaskW = 12;
    localparam int KeysW = 8;

    localparam logic [ModeW-1:0] MODE_UNINIT      = 4'd0;
    localparam logic [ModeW-1:0] MODE_INIT        = 4'd1;
    localparam logic [ModeW-1:0] MODE_PREP_STBY   = 4'd2;
    localparam logic [ModeW-1:0] MODE_STANDBY     = 4'd3;
    localparam logic [ModeW-1:0] MODE_CONNECTED   = 4'd4;
    localparam logic [ModeW-1:0] MODE_UNCONNECTED = 4'd5;
    localparam logic [ModeW-1:0] MODE_CONNECTING  = 4'd6;
    localparam logic [ModeW-1:0] MODE_RESETTING   = 4'd7;
    localparam logic [ModeW-1:0] MODE_PREP_SPEC   = 4'd8;
    localparam logic [ModeW-1:0] MODE_SPECIAL     = 4'd9;
    localparam logic [ModeW-1:0] MODE_UPDATING    = 4'd10;

    localparam logic [MaskW-1:0] MASK_OFF       = 12'h000;
    localparam logic [MaskW-1:0] MASK_FULL      = 12'h7FF;
    localparam logic [MaskW-1:0] MASK_UNCONN    = 12'h6F3;
    localparam logic [MaskW-1:0] MASK_PS_LINKED = 12'h723;
    localparam logic [MaskW-1:0] MASK_PS_UNCONN = 12'h621;
    localparam logic [MaskW-1:0] MASK_STANDBY   = 12'h000;
    localparam logic [MaskW-1:0] MASK_PREP_SPEC = 12'h5A1;
    localparam logic [MaskW-1:0] MASK_RESETTING = 12'hF03;
    localparam logic [MaskW-1:0] MASK_UPDATING  = 12'h721;

    typedef struct packed {
        logic             host_linked;
        logic             idle_event_valid;
        logic             idle_event_kind;
        logic             special_request;
        logic             reset_request;
        logic             update_request;
        logic             connect_request;
        logic             switch_recorded;
        logic             message_valid;
        logic [KeysW-1:0] message_keys;
        logic             message_event;
    } pmc_event_t;

endpackage

`default_nettype wire

// ===== design/power_mode_controller_top.sv =====
// Top level of the power mode controller: request register, mode state and result register.
// Requests pass the request register, then the mode and mask registers (m_valid rises).
// Throughput: one request per cycle with m_ready high; mode/mask regs close the only loop.
// s_ready stays high while the result register drains or is empty.
// Reset: mode goes to initializing, mask clears to all off, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module power_mode_controller_top (
    input  wire  logic                          aclk,
    input  wire  logic                          aresetn,
    input  wire  logic                          s_valid,
    output logic                                s_ready,
    input  wire  logic                          s_host_linked,
    input  wire  logic                          s_idle_event_valid,
    input  wire  logic                          s_idle_event_kind,
    input  wire  logic                          s_special_request,
    input  wire  logic                          s_reset_request,
    input  wire  logic                          s_update_request,
    input  wire  logic                          s_connect_request,
    input  wire  logic                          s_switch_recorded,
    input  wire  logic                          s_message_valid,
    input  wire  logic [pmc_pkg::KeysW-1:0]     s_message_keys,
    input  wire  logic                          s_message_event,
    output logic                                m_valid,
    input  wire  logic                          m_ready,
    output logic       [pmc_pkg::ModeW-1:0]     m_mode,
    output logic       [pmc_pkg::MaskW-1:0]     m_enable_mask
);
    import pmc_pkg::*;

    pmc_event_t         ev_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic [ModeW-1:0]   mode_reg;
    logic [MaskW-1:0]   mask_reg;
    logic [ModeW-1:0]   mode_next;
    logic [MaskW-1:0]   mask_next;
    logic               advance;

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    pmc_trans u_trans (
        .ev       (ev_reg),
        .mode_cur (mode_reg),
        .mask_cur (mask_reg),
        .mode_new (mode_next),
        .mask_new (mask_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_INIT;
            mask_reg      <= MASK_OFF;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                mask_reg      <= mask_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ev_reg.host_linked      <= s_host_linked;
            ev_reg.idle_event_valid <= s_idle_event_valid;
            ev_reg.idle_event_kind  <= s_idle_event_kind;
            ev_reg.special_request  <= s_special_request;
            ev_reg.reset_request    <= s_reset_request;
            ev_reg.update_request   <= s_update_request;
            ev_reg.connect_request  <= s_connect_request;
            ev_reg.switch_recorded  <= s_switch_recorded;
            ev_reg.message_valid    <= s_message_valid;
            ev_reg.message_keys     <= s_message_keys;
            ev_reg.message_event    <= s_message_event;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_mode        = mode_reg;
    assign m_enable_mask = mask_reg;

endmodule

`default_nettype wire

// ===== design/pmc_trans.sv =====
// Prioritized mode transition and enable mask selection for one request.
`timescale 1ns / 1ps
`default_nettype none

module pmc_trans (
    input  wire pmc_pkg::pmc_event_t         ev,
    input  wire logic [pmc_pkg::ModeW-1:0]   mode_cur,
    input  wire logic [pmc_pkg::MaskW-1:0]   mask_cur,
    output logic      [pmc_pkg::ModeW-1:0]   mode_new,
    output logic      [pmc_pkg::MaskW-1:0]   mask_new
);
    import pmc_pkg::*;

    logic inactive;
    logic stby_cond;

    assign inactive  = ev.idle_event_valid & ~ev.idle_event_kind;
    assign stby_cond = (ev.message_valid & ~ev.message_event) | inactive
                     | (ev.switch_recorded & ev.message_valid & ev.message_event);

    always_comb begin
        mode_new = mode_cur;
        mask_new = mask_cur;
        case (mode_cur)
            MODE_INIT: begin
                mode_new = ev.host_linked ? MODE_CONNECTED : MODE_CONNECTING;
                mask_new = MASK_FULL;
            end
            MODE_PREP_STBY: begin
                if (inactive) begin
                    mode_new = MODE_STANDBY;
                    mask_new = MASK_STANDBY;
                end
            end
            MODE_STANDBY: begin
                if (ev.host_linked) begin
                    mode_new = MODE_CONNECTED;
                    mask_new = MASK_FULL;
                end else begin
                    mode_new = MODE_UNCONNECTED;
                    mask_new = MASK_UNCONN;
                end
            end
            MODE_CONNECTED: begin
                if (ev.special_request) begin
                    mode_new = MODE_PREP_SPEC;
                    mask_new = MASK_PREP_SPEC;
                end else if (ev.reset_request) begin
                    mode_new = MODE_RESETTING;
                    mask_new = MASK_RESETTING;
                end else if (ev.update_request) begin
                    mode_new = MODE_UPDATING;
                    mask_new = MASK_UPDATING;
                end else if (ev.connect_request) begin
                    mode_new = MODE_CONNECTING;
                    mask_new = MASK_FULL;
                end else if (~ev.host_linked | stby_cond) begin
                    mode_new = MODE_PREP_STBY;
                    mask_new = MASK_PS_LINKED;
                end
            end
            MODE_UNCONNECTED: begin
                if (ev.special_request) begin
                    mode_new = MODE_PREP_SPEC;
                    mask_new = MASK_PREP_SPEC;
                end else if (ev.reset_request) begin
                    mode_new = MODE_RESETTING;
                    mask_new = MASK_RESETTING;
                end else if (ev.connect_request) begin
                    mode_new = MODE_CONNECTING;
                    mask_new = MASK_FULL;
                end else if (ev.message_valid) begin
                    if (ev.message_keys != '0) begin
                        mode_new = MODE_CONNECTING;
                        mask_new = MASK_FULL;
                    end
                end else if (stby_cond) begin
                    mode_new = MODE_PREP_STBY;
                    mask_new = MASK_PS_UNCONN;
                end
            end
            MODE_CONNECTING: begin
                if (stby_cond) begin
                    mode_new = MODE_PREP_STBY;
                    mask_new = MASK_PS_LINKED;
                end else if (ev.special_request) begin
                    mode_new = MODE_PREP_SPEC;
                    mask_new = MASK_PREP_SPEC;
                end
            end
            MODE_PREP_SPEC: begin
                if (inactive) begin
                    mode_new = MODE_SPECIAL;
                end
            end
            default: begin
                mode_new = mode_cur;
                mask_new = mask_cur;
            end
        endcase
    end

endmodule

`default_nettype wire
